// ----- hw/rtl/ctsp_pkg.sv -----
// Shared constants, arctangent table and a helper function of the
// cartesian-to-spherical point converter. No dependencies.
package ctsp_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int ANGLE_FRAC_BITS = 7;

  localparam int CORDIC_STEPS = 31;
  localparam int SQRT_STEPS   = 32;
  localparam int CW           = 36;
  localparam int AW           = 34;
  localparam int ROOT_W       = 33;

  localparam int REG_OUT_MODE = 0;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
  };

  // ceil(log2(v)), zero for v == 0
  function automatic logic [6:0] clog2_64(input logic [63:0] v);
    logic [63:0] d;
    logic [6:0]  n;
    d = v - 64'd1;
    n = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (d[i]) n = 7'(i + 1);
    end
    return (v == 64'd0) ? 7'd0 : n;
  endfunction

endpackage

// ----- hw/rtl/cartesian_to_spherical_point.sv -----
// Top level of the lidar point converter: front end, square roots, CORDICs, scaling.
// Depends on ctsp_pkg, ctsp_sqrt and ctsp_cordic.
//
//   channel | handshake         | ports
//   --------+-------------------+----------------------------------------------
//   input   | start && !busy    | in_x_mm, in_y_mm, in_z_mm, in_reflectivity,
//           |                   | in_point_valid
//   result  | out_valid strobe  | out_chan0, out_chan1, out_chan2, out_chan3
//   config  | psel/penable/pwr. | paddr, pwdata, prdata, pready
//
// One transaction enters every cycle; busy is always low.
// The path from start to out_valid runs through 5 front stages, the 32-step
// square root plus rounding, the 31-step CORDIC, one multiply and one output stage.
// Synchronous active-low reset clears the output mode and the valid pipeline.
// The receiver cannot stall; each result is shown for exactly one cycle.
module cartesian_to_spherical_point #(
  parameter int COORD_WIDTH     = ctsp_pkg::COORD_WIDTH,
  parameter int ANGLE_FRAC_BITS = ctsp_pkg::ANGLE_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_x_mm,
  input  logic signed [COORD_WIDTH-1:0] in_y_mm,
  input  logic signed [COORD_WIDTH-1:0] in_z_mm,
  input  logic [7:0]                    in_reflectivity,
  input  logic                          in_point_valid,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH:0]   out_chan0,
  output logic signed [COORD_WIDTH-1:0] out_chan1,
  output logic signed [COORD_WIDTH-1:0] out_chan2,
  output logic [7:0]                    out_chan3
);

  localparam int W        = COORD_WIDTH;
  localparam int F        = ANGLE_FRAC_BITS;
  localparam int CW       = ctsp_pkg::CW;
  localparam int AW       = ctsp_pkg::AW;
  localparam int RTW      = ctsp_pkg::ROOT_W;
  localparam int MW       = 2 * W;
  localparam int HW       = 2 * W + 1;
  localparam int SW       = 2 * W + 2;
  localparam int KW       = 10 + F;
  localparam int PW       = AW + KW;
  localparam int RW       = PW - 31;
  localparam int LF       = 5;
  localparam int SQ_LAT   = ctsp_pkg::SQRT_STEPS + 1;
  localparam int CD_LAT   = ctsp_pkg::CORDIC_STEPS;
  localparam int PASS_LAT = LF + SQ_LAT + CD_LAT + 1;
  localparam int LAT      = PASS_LAT + 1;

  localparam logic signed [KW-1:0] KSCALE = KW'(360 * (2 ** F));
  localparam logic signed [RW-1:0] LIM_AZ = RW'(180 * (2 ** F));
  localparam logic signed [RW-1:0] LIM_EL = RW'(90 * (2 ** F));
  localparam logic signed [AW-1:0] HALF_TURN = AW'(64'd1 << 31);

  function automatic logic signed [RW-1:0] ang_round(
    input logic signed [PW-1:0] p,
    input logic signed [RW-1:0] lim
  );
    logic [PW-1:0]        m;
    logic [PW-1:0]        t;
    logic signed [RW-1:0] q;
    logic signed [RW-1:0] r;
    m = p[PW-1] ? PW'(-p) : PW'(p);
    t = m + (PW'(1) << 31);
    q = RW'(t[PW-1:32]);
    r = p[PW-1] ? -q : q;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // configuration
  logic mode_r;
  logic accept;

  assign accept = start && !busy;
  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'(ctsp_pkg::REG_OUT_MODE)) ? {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == 1'(ctsp_pkg::REG_OUT_MODE)) begin
      mode_r <= pwdata[0];
    end
  end

  // valid and pass-through lines
  logic                 vd_r [PASS_LAT];
  logic                 pv_r [PASS_LAT];
  logic [7:0]           rf_r [PASS_LAT];
  logic signed [W-1:0]  px_r [PASS_LAT];
  logic signed [W-1:0]  py_r [PASS_LAT];
  logic signed [W-1:0]  pz_r [PASS_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PASS_LAT; i++) vd_r[i] <= 1'b0;
    end else begin
      vd_r[0] <= accept;
      for (int i = 1; i < PASS_LAT; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    pv_r[0] <= in_point_valid;
    rf_r[0] <= in_reflectivity;
    px_r[0] <= in_x_mm;
    py_r[0] <= in_y_mm;
    pz_r[0] <= in_z_mm;
    for (int i = 1; i < PASS_LAT; i++) begin
      pv_r[i] <= pv_r[i-1];
      rf_r[i] <= rf_r[i-1];
      px_r[i] <= px_r[i-1];
      py_r[i] <= py_r[i-1];
      pz_r[i] <= pz_r[i-1];
    end
  end

  // front end
  logic [W-1:0]  mx1_r, my1_r, mz1_r, mx2_r, my2_r, mz2_r, mx3_r, my3_r, mz3_r;
  logic [W-1:0]  mx4_r, my4_r, mz4_r;
  logic          xn1_r, yn1_r, zn1_r, xn2_r, yn2_r, zn2_r, xn3_r, yn3_r, zn3_r;
  logic          xn4_r, yn4_r, zn4_r;
  logic [MW-1:0] sqx2_r, sqy2_r, sqz2_r;
  logic [HW-1:0] hsq3_r, hsq4_r;
  logic [SW-1:0] sum3_r, sum4_r;
  logic [4:0]    saz4_r, sel4_r;
  logic [6:0]    cx, cy, cz, ch, cxy, ca, cb;
  logic [CW-1:0] ysh, zsh, zsg;

  logic signed [CW-1:0] xa5_r, ya5_r, zs5_r;
  logic signed [AW-1:0] off5_r;
  logic [63:0]          hn5_r, sum5_r;
  logic                 azz5_r, elz5_r;

  always_ff @(posedge clk) begin
    mx1_r <= in_x_mm[W-1] ? W'(-in_x_mm) : W'(in_x_mm);
    my1_r <= in_y_mm[W-1] ? W'(-in_y_mm) : W'(in_y_mm);
    mz1_r <= in_z_mm[W-1] ? W'(-in_z_mm) : W'(in_z_mm);
    xn1_r <= in_x_mm[W-1];
    yn1_r <= in_y_mm[W-1];
    zn1_r <= in_z_mm[W-1];

    sqx2_r <= MW'(mx1_r) * MW'(mx1_r);
    sqy2_r <= MW'(my1_r) * MW'(my1_r);
    sqz2_r <= MW'(mz1_r) * MW'(mz1_r);
    {mx2_r, my2_r, mz2_r, xn2_r, yn2_r, zn2_r} <=
      {mx1_r, my1_r, mz1_r, xn1_r, yn1_r, zn1_r};

    hsq3_r <= HW'(sqx2_r) + HW'(sqy2_r);
    sum3_r <= SW'(sqx2_r) + SW'(sqy2_r) + SW'(sqz2_r);
    {mx3_r, my3_r, mz3_r, xn3_r, yn3_r, zn3_r} <=
      {mx2_r, my2_r, mz2_r, xn2_r, yn2_r, zn2_r};

    saz4_r <= 5'(7'd31 - cxy);
    sel4_r <= 5'((ca < cb) ? ca : cb);
    hsq4_r <= hsq3_r;
    sum4_r <= sum3_r;
    {mx4_r, my4_r, mz4_r, xn4_r, yn4_r, zn4_r} <=
      {mx3_r, my3_r, mz3_r, xn3_r, yn3_r, zn3_r};

    xa5_r  <= signed'(CW'(mx4_r) << saz4_r);
    ya5_r  <= signed'((xn4_r != yn4_r) ? -ysh : ysh);
    zs5_r  <= signed'(zsg);
    off5_r <= !xn4_r ? AW'(0) : (yn4_r ? -HALF_TURN : HALF_TURN);
    hn5_r  <= 64'(hsq4_r) << {sel4_r, 1'b0};
    sum5_r <= 64'(sum4_r);
    azz5_r <= (mx4_r == '0) && (my4_r == '0);
    elz5_r <= (mx4_r == '0) && (my4_r == '0) && (mz4_r == '0);
  end

  always_comb begin
    cx  = ctsp_pkg::clog2_64(64'(mx3_r));
    cy  = ctsp_pkg::clog2_64(64'(my3_r));
    cz  = ctsp_pkg::clog2_64(64'(mz3_r));
    ch  = ctsp_pkg::clog2_64(64'(hsq3_r));
    cxy = (cx > cy) ? cx : cy;
    ca  = 7'd31 - cz;
    cb  = (ch > 7'd62) ? 7'd0 : ((7'd62 - ch) >> 1);
    ysh = CW'(my4_r) << saz4_r;
    zsh = CW'(mz4_r) << sel4_r;
    zsg = zn4_r ? -zsh : zsh;
  end

  // square roots
  logic [RTW-1:0] range_root, h_root;

  ctsp_sqrt u_sqrt_range (.clk(clk), .n_i(sum5_r), .root_o(range_root));
  ctsp_sqrt u_sqrt_h     (.clk(clk), .n_i(hn5_r),  .root_o(h_root));

  logic signed [CW-1:0] axd_r [SQ_LAT];
  logic signed [CW-1:0] ayd_r [SQ_LAT];
  logic signed [CW-1:0] zd_r  [SQ_LAT];
  logic signed [AW-1:0] od_r  [SQ_LAT];
  logic                 azd_r [SQ_LAT];
  logic                 eld_r [SQ_LAT];

  always_ff @(posedge clk) begin
    axd_r[0] <= xa5_r;
    ayd_r[0] <= ya5_r;
    zd_r[0]  <= zs5_r;
    od_r[0]  <= off5_r;
    azd_r[0] <= azz5_r;
    eld_r[0] <= elz5_r;
    for (int i = 1; i < SQ_LAT; i++) begin
      axd_r[i] <= axd_r[i-1];
      ayd_r[i] <= ayd_r[i-1];
      zd_r[i]  <= zd_r[i-1];
      od_r[i]  <= od_r[i-1];
      azd_r[i] <= azd_r[i-1];
      eld_r[i] <= eld_r[i-1];
    end
  end

  // angles
  logic signed [AW-1:0] az_ang, el_ang;

  ctsp_cordic u_cordic_az (
    .clk(clk), .x_i(axd_r[SQ_LAT-1]), .y_i(ayd_r[SQ_LAT-1]),
    .ang_i(od_r[SQ_LAT-1]), .ang_o(az_ang)
  );

  ctsp_cordic u_cordic_el (
    .clk(clk), .x_i(signed'(CW'(h_root))), .y_i(zd_r[SQ_LAT-1]),
    .ang_i(AW'(0)), .ang_o(el_ang)
  );

  logic [W:0] rd_r  [CD_LAT+1];
  logic       rza_r [CD_LAT+1];
  logic       rze_r [CD_LAT+1];

  always_ff @(posedge clk) begin
    rd_r[0]  <= range_root[W:0];
    rza_r[0] <= azd_r[SQ_LAT-1];
    rze_r[0] <= eld_r[SQ_LAT-1];
    for (int i = 1; i <= CD_LAT; i++) begin
      rd_r[i]  <= rd_r[i-1];
      rza_r[i] <= rza_r[i-1];
      rze_r[i] <= rze_r[i-1];
    end
  end

  logic signed [PW-1:0] paz_r, pel_r;

  always_ff @(posedge clk) begin
    paz_r <= az_ang * KSCALE;
    pel_r <= el_ang * KSCALE;
  end

  // output stage
  logic signed [W:0]   chan0_nxt, chan0_r;
  logic signed [W-1:0] chan1_nxt, chan2_nxt, chan1_r, chan2_r;
  logic [7:0]          chan3_nxt, chan3_r;
  logic                out_valid_r;
  logic signed [RW-1:0] az_deg, el_deg;

  always_comb begin
    az_deg = ang_round(paz_r, LIM_AZ);
    el_deg = ang_round(pel_r, LIM_EL);
    chan0_nxt = '0;
    chan1_nxt = '0;
    chan2_nxt = '0;
    chan3_nxt = 8'd0;
    if (pv_r[PASS_LAT-1]) begin
      chan3_nxt = rf_r[PASS_LAT-1];
      if (mode_r) begin
        chan0_nxt = signed'(rd_r[CD_LAT]);
        chan1_nxt = rza_r[CD_LAT] ? '0 : W'(az_deg);
        chan2_nxt = rze_r[CD_LAT] ? '0 : W'(el_deg);
      end else begin
        chan0_nxt = (W+1)'(px_r[PASS_LAT-1]);
        chan1_nxt = py_r[PASS_LAT-1];
        chan2_nxt = pz_r[PASS_LAT-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vd_r[PASS_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    chan0_r <= chan0_nxt;
    chan1_r <= chan1_nxt;
    chan2_r <= chan2_nxt;
    chan3_r <= chan3_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_chan0 = chan0_r;
  assign out_chan1 = chan1_r;
  assign out_chan2 = chan2_r;
  assign out_chan3 = chan3_r;

endmodule

// ----- hw/rtl/ctsp_sqrt.sv -----
// Pipelined rounded integer square root, one result bit per stage.
// Depends on ctsp_pkg.
module ctsp_sqrt (
  input  logic                        clk,
  input  logic [63:0]                 n_i,
  output logic [ctsp_pkg::ROOT_W-1:0] root_o
);

  localparam int STEPS = ctsp_pkg::SQRT_STEPS;

  logic [63:0] rem_r [STEPS];
  logic [63:0] res_r [STEPS];
  logic [ctsp_pkg::ROOT_W-1:0] root_r;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] rem_in, res_in, trial, rem_nxt, res_nxt;
    if (k == 0) begin : g_first
      assign rem_in = n_i;
      assign res_in = 64'd0;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end
    always_comb begin
      trial = res_in + BIT;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      res_r[k] <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rem_r[STEPS-1] > res_r[STEPS-1]) begin
      root_r <= ctsp_pkg::ROOT_W'(res_r[STEPS-1] + 64'd1);
    end else begin
      root_r <= ctsp_pkg::ROOT_W'(res_r[STEPS-1]);
    end
  end

  assign root_o = root_r;

endmodule

// ----- hw/rtl/ctsp_cordic.sv -----
// Pipelined vectoring CORDIC, one rotation per stage, angle in 2^-32 turn.
// Depends on ctsp_pkg.
module ctsp_cordic (
  input  logic                           clk,
  input  logic signed [ctsp_pkg::CW-1:0] x_i,
  input  logic signed [ctsp_pkg::CW-1:0] y_i,
  input  logic signed [ctsp_pkg::AW-1:0] ang_i,
  output logic signed [ctsp_pkg::AW-1:0] ang_o
);

  localparam int STEPS = ctsp_pkg::CORDIC_STEPS;
  localparam int CW    = ctsp_pkg::CW;
  localparam int AW    = ctsp_pkg::AW;

  logic signed [CW-1:0] x_r   [STEPS];
  logic signed [CW-1:0] y_r   [STEPS];
  logic signed [AW-1:0] ang_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN = AW'(ctsp_pkg::ATAN_TAB[i]);
    logic signed [CW-1:0] x_in, y_in, dx, dy;
    logic signed [AW-1:0] a_in;
    if (i == 0) begin : g_first
      assign x_in = x_i;
      assign y_in = y_i;
      assign a_in = ang_i;
    end else begin : g_rest
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign a_in = ang_r[i-1];
    end
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    always_ff @(posedge clk) begin
      if (!y_in[CW-1]) begin
        x_r[i]   <= x_in + dx;
        y_r[i]   <= y_in - dy;
        ang_r[i] <= a_in + ATAN;
      end else begin
        x_r[i]   <= x_in - dx;
        y_r[i]   <= y_in + dy;
        ang_r[i] <= a_in - ATAN;
      end
    end
  end

  assign ang_o = ang_r[STEPS-1];

endmodule

// ----- hw/rtl/ctsp_checker.sv -----
// Port-level checks of the point converter and their bind to the top level.
// Depends on cartesian_to_spherical_point.
module ctsp_checker #(
  parameter int COORD_WIDTH = 24,
  parameter int LAT         = 71
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_point_valid,
  input logic [7:0]                    in_reflectivity,
  input logic                          out_valid,
  input logic signed [COORD_WIDTH:0]   out_chan0,
  input logic signed [COORD_WIDTH-1:0] out_chan1,
  input logic signed [COORD_WIDTH-1:0] out_chan2,
  input logic [7:0]                    out_chan3
);

  logic [$clog2(LAT+1)-1:0] warm_r;
  logic                     warm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
    end else if (!warm) begin
      warm_r <= warm_r + 1'b1;
    end
  end

  assign warm = (warm_r == ($clog2(LAT+1))'(LAT));

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> (out_valid == $past(start && !busy, LAT)))
    else $error("result strobe does not match accepted transaction");

  a_refl: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && out_valid) |->
      (out_chan3 == $past(in_point_valid ? in_reflectivity : 8'd0, LAT)))
    else $error("intensity mismatch");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && out_valid && !$past(in_point_valid, LAT)) |->
      (out_chan0 == '0 && out_chan1 == '0 && out_chan2 == '0))
    else $error("empty slot gave nonzero coordinates");

endmodule

bind cartesian_to_spherical_point ctsp_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .LAT(LAT)
) u_ctsp_checker (.*);

// ----- verif/cartesian_to_spherical_point_tb.sv -----
// Self-checking testbench of cartesian_to_spherical_point: a directed table, then random points
// in both coordinate modes, checked against a fixed-point predictor of the range and CORDIC angles.
// Depends on ctsp_pkg and the RTL of cartesian_to_spherical_point only.
module cartesian_to_spherical_point_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CWID = ctsp_pkg::COORD_WIDTH;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum bit {MODE_CARTESIAN = 1'b0, MODE_SPHERICAL = 1'b1} out_mode_e;

  typedef struct {
    logic signed [CWID:0]   chan0;
    logic signed [CWID-1:0] chan1;
    logic signed [CWID-1:0] chan2;
    logic [7:0]             chan3;
  } point_out_t;

  typedef struct {
    out_mode_e mode;
    int        x, y, z;
    int        refl;
    bit        valid;
    bit        typed;
    int        e0, e1, e2, e3;
  } table_row_t;

  logic clk, rst_n, start, busy;
  logic signed [CWID-1:0] in_x_mm, in_y_mm, in_z_mm;
  logic [7:0] in_reflectivity;
  logic in_point_valid;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic out_valid;
  logic signed [CWID:0] out_chan0;
  logic signed [CWID-1:0] out_chan1, out_chan2;
  logic [7:0] out_chan3;

  cartesian_to_spherical_point dut (.*);

  point_out_t pending_points[$];
  out_mode_e  mode_shadow;
  int         errors, accepted_pts, checked_pts, idle_cycles, sender_gap_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [63:0] root_rounded(logic [63:0] n);
    logic [63:0] rem, res, b;
    rem = n;
    res = '0;
    b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return (rem > res) ? res + 64'd1 : res;
  endfunction

  function automatic longint vector_turns(longint x, longint y);
    longint a, dx, dy;
    a = 0;
    for (int i = 0; i < ctsp_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; a += longint'(ctsp_pkg::ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; a -= longint'(ctsp_pkg::ATAN_TAB[i]);
      end
    end
    return a;
  endfunction

  function automatic longint turns_to_units(longint a, longint lim_deg);
    longint prod, r, lim;
    logic [63:0] q;
    prod = a * (longint'(360) << ctsp_pkg::ANGLE_FRAC_BITS);
    q = (abs64(prod) + (64'd1 << 31)) >> 32;
    lim = lim_deg << ctsp_pkg::ANGLE_FRAC_BITS;
    r = (prod < 0) ? -longint'(q) : longint'(q);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint scaled(longint v, int s);
    longint m;
    m = longint'(abs64(v) << s);
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint azimuth_units(longint x, longint y);
    int s;
    longint xs, ys, off;
    s = 0;
    off = 0;
    if (x == 0 && y == 0) return 0;
    while (s < 31 && abs64(x) <= ((64'd1 << 31) >> (s + 1)) &&
           abs64(y) <= ((64'd1 << 31) >> (s + 1))) s++;
    xs = scaled(x, s);
    ys = scaled(y, s);
    if (xs < 0) begin
      xs = -xs;
      ys = -ys;
      off = (y >= 0) ? (longint'(1) << 31) : -(longint'(1) << 31);
    end
    return turns_to_units(off + vector_turns(xs, ys), 180);
  endfunction

  function automatic longint elevation_units(logic [63:0] hsq, longint z);
    int s;
    s = 0;
    if (hsq == 0 && z == 0) return 0;
    while (s < 31 && hsq <= ((64'd1 << 62) >> (2 * (s + 1))) &&
           abs64(z) <= ((64'd1 << 31) >> (s + 1))) s++;
    return turns_to_units(vector_turns(longint'(root_rounded(hsq << (2 * s))),
                                       scaled(z, s)), 90);
  endfunction

  function automatic point_out_t convert_point(out_mode_e mode, longint x, longint y,
                                               longint z, logic [7:0] refl, bit valid);
    point_out_t p;
    logic [63:0] hsq;
    p = '{default: '0};
    if (valid) begin
      p.chan3 = refl;
      if (mode == MODE_CARTESIAN) begin
        p.chan0 = (CWID+1)'(x); p.chan1 = CWID'(y); p.chan2 = CWID'(z);
      end else begin
        hsq = abs64(x) * abs64(x) + abs64(y) * abs64(y);
        p.chan0 = (CWID+1)'(root_rounded(hsq + abs64(z) * abs64(z)));
        p.chan1 = CWID'(azimuth_units(x, y));
        p.chan2 = CWID'(elevation_units(hsq, z));
      end
    end
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_points.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(out_mode_e mode);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 3'(ctsp_pkg::REG_OUT_MODE * 4); pwdata <= 32'(mode);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mode_shadow = mode;
  endtask

  // drive one point and hold it until accepted; typed expectation overrides the predictor
  task automatic send_point(int x, int y, int z, int refl, bit valid,
                            bit typed, point_out_t typed_exp);
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_x_mm <= CWID'(x); in_y_mm <= CWID'(y); in_z_mm <= CWID'(z);
    in_reflectivity <= 8'(refl); in_point_valid <= valid;
    do @(posedge clk); while (busy);
    pending_points.push_back(typed ? typed_exp :
                             convert_point(mode_shadow, longint'(x), longint'(y),
                                           longint'(z), 8'(refl), valid));
    accepted_pts++;
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int random_coord();
    case ($urandom_range(5))
      0: return int'({{8{1'b0}}, 24'($urandom)} << 8) >>> 8;
      1: return $urandom_range(2000) - 1000;
      2: return $urandom_range(1) ? 8388607 : -8388608;
      3: return 0;
      4: return $urandom_range(131072) - 65536;
      default: return $urandom_range(16777215) - 8388608;
    endcase
  endfunction

  always @(posedge clk) begin
    point_out_t e;
    if (out_valid) begin
      if (pending_points.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        e = pending_points.pop_front();
        checked_pts++;
        if (out_chan0 !== e.chan0) begin
          $error("chan0 expected %0d got %0d", e.chan0, out_chan0); errors++;
        end
        if (out_chan1 !== e.chan1) begin
          $error("chan1 expected %0d got %0d", e.chan1, out_chan1); errors++;
        end
        if (out_chan2 !== e.chan2) begin
          $error("chan2 expected %0d got %0d", e.chan2, out_chan2); errors++;
        end
        if (out_chan3 !== e.chan3) begin
          $error("chan3 expected %0d got %0d", e.chan3, out_chan3); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  table_row_t dir_rows[19] = '{
    '{MODE_CARTESIAN, 8388607, -8388608, 8388607, 255, 1, 1, 8388607, -8388608, 8388607, 255},
    '{MODE_CARTESIAN, -8388608, 8388607, -8388608, 0, 1, 1, -8388608, 8388607, -8388608, 0},
    '{MODE_CARTESIAN, 123, -45, 6, 77, 0, 1, 0, 0, 0, 0},
    '{MODE_CARTESIAN, -1, -1, -1, 128, 1, 1, -1, -1, -1, 128},
    '{MODE_SPHERICAL, 0, 0, 0, 9, 1, 1, 0, 0, 0, 9},
    '{MODE_SPHERICAL, -5, 0, 0, 1, 1, 1, 5, 23040, 0, 1},
    '{MODE_SPHERICAL, 100, 0, 0, 2, 1, 1, 100, 0, 0, 2},
    '{MODE_SPHERICAL, 0, 0, 7, 3, 1, 1, 7, 0, 11520, 3},
    '{MODE_SPHERICAL, 0, 0, -7, 3, 1, 1, 7, 0, -11520, 3},
    '{MODE_SPHERICAL, 5, 6, 7, 200, 0, 1, 0, 0, 0, 0},
    '{MODE_SPHERICAL, -8388608, -8388608, -8388608, 255, 1, 0, 0, 0, 0, 0},
    '{MODE_SPHERICAL, 8388607, 8388607, 8388607, 255, 1, 0, 0, 0, 0, 0},
    '{MODE_SPHERICAL, -8388608, 1, 0, 4, 1, 0, 0, 0, 0, 0},
    '{MODE_SPHERICAL, -8388608, -1, 0, 4, 1, 0, 0, 0, 0, 0},
    '{MODE_SPHERICAL, 0, 8388607, -8388608, 5, 1, 0, 0, 0, 0, 0},
    '{MODE_SPHERICAL, 0, -3, 0, 6, 1, 0, 0, 0, 0, 0},
    '{MODE_SPHERICAL, 1, 1, 1, 7, 1, 0, 0, 0, 0, 0},
    '{MODE_SPHERICAL, 3000, -4000, 12000, 8, 1, 0, 0, 0, 0, 0},
    '{MODE_SPHERICAL, -2, 3, -8388608, 9, 1, 0, 0, 0, 0, 0}
  };

  initial begin
    point_out_t t;
    out_mode_e m;
    int gap_pct[3] = '{23, 58, 0};
    accepted_pts = 0;
    sender_gap_pct = 0;
    mode_shadow = MODE_CARTESIAN;
    rst_n = 1'b0; start = 1'b0;
    in_x_mm = '0; in_y_mm = '0; in_z_mm = '0; in_reflectivity = '0; in_point_valid = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != mode_shadow) begin
        stop_sending();
        wait_drained();
        write_mode(dir_rows[i].mode);
      end
      t.chan0 = (CWID+1)'(dir_rows[i].e0); t.chan1 = CWID'(dir_rows[i].e1);
      t.chan2 = CWID'(dir_rows[i].e2); t.chan3 = 8'(dir_rows[i].e3);
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].refl,
                 dir_rows[i].valid, dir_rows[i].typed, t);
    end

    foreach (gap_pct[p]) begin
      sender_gap_pct = gap_pct[p];
      for (int k = 0; k < 2; k++) begin
        m = out_mode_e'((k + p) % 2);
        stop_sending();
        wait_drained();
        write_mode(m);
        repeat (200) begin
          send_point(random_coord(), random_coord(), random_coord(), $urandom_range(255),
                     $urandom_range(9) != 0, 1'b0, t);
        end
      end
    end
    stop_sending();
    wait_drained();
    repeat (80) @(posedge clk);

    $display("covered %0d points, %0d results checked, both modes, three sender gap rates",
             accepted_pts, checked_pts);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ctsp_pkg.sv
hw/rtl/ctsp_sqrt.sv
hw/rtl/ctsp_cordic.sv
hw/rtl/cartesian_to_spherical_point.sv
hw/rtl/ctsp_checker.sv
verif/cartesian_to_spherical_point_tb.sv
